/* rtl/core/rau_pkg.sv */
// Shared constants and opcode and status codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
   localparam int GcdBits = 32;
   localparam int GcdShiftBits = $clog2(GcdBits + 1);
   localparam int DivBits = 65;
   localparam int DivCntBits = $clog2(DivBits + 1);
   localparam int MulBits = 64;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_POW = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_NON_INT = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;
endpackage
`default_nettype wire

/* rtl/core/rau_gcd.sv */
// Iterative binary greatest common divisor, one step per cycle.
`default_nettype none
module rau_gcd (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rau_pkg::GcdBits-1:0] op_x,
   input  wire logic [rau_pkg::GcdBits-1:0] op_y,
   output logic                             done,
   output logic [rau_pkg::GcdBits-1:0]      result
);
   import rau_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [GcdBits-1:0]      x_ff;
   logic [GcdBits-1:0]      y_ff;
   logic [GcdShiftBits-1:0] k_ff;
   logic [GcdBits-1:0]      result_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         x_ff <= op_x;
         y_ff <= op_y;
         k_ff <= '0;
      end else if (busy_ff) begin
         if (x_ff == '0) begin
            result_ff <= y_ff << k_ff;
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else if (y_ff == '0) begin
            result_ff <= x_ff << k_ff;
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
   end

   assign done = done_ff;
   assign result = result_ff;
endmodule
`default_nettype wire

/* rtl/core/rau_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rau_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rau_pkg::DivBits-1:0] dividend,
   input  wire logic [31:0]                 divisor,
   output logic                             done,
   output logic [rau_pkg::DivBits-1:0]      quotient,
   output logic [31:0]                      remainder
);
   import rau_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [DivBits-1:0]    quot_ff;
   logic [31:0]           rem_ff;
   logic [31:0]           den_ff;
   logic [DivCntBits-1:0] count_ff;
   logic [32:0]           partial;
   logic [32:0]           diff;
   logic                  fits;

   assign partial = {rem_ff, quot_ff[DivBits-1]};
   assign fits = partial >= {1'b0, den_ff};
   assign diff = partial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         quot_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         count_ff <= DivCntBits'(DivBits);
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[DivBits-2:0], fits};
         rem_ff <= fits ? diff[31:0] : partial[31:0];
         count_ff <= count_ff - 1'b1;
         if (count_ff == DivCntBits'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quotient = quot_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

/* rtl/core/rau_mul.sv */
// Shift-and-add multiplier that stops when the multiplier runs out of ones.
`default_nettype none
module rau_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rau_pkg::MulBits-1:0]   op_a,
   input  wire logic [rau_pkg::MulBits-1:0]   op_b,
   output logic                               done,
   output logic [2*rau_pkg::MulBits-1:0]      product
);
   import rau_pkg::*;

   logic                   busy_ff;
   logic                   done_ff;
   logic [2*MulBits-1:0]   acc_ff;
   logic [2*MulBits-1:0]   mcand_ff;
   logic [MulBits-1:0]     mplier_ff;

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         acc_ff <= '0;
         mcand_ff <= {{MulBits{1'b0}}, op_a};
         mplier_ff <= op_b;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

/* rtl/core/rational_arithmetic_unit.sv */
// Top level: sequencer that drives the shared GCD, divider and multiplier units.
// A zero denominator goes from the check straight to the result; add, multiply
// and divide run through the divider and the GCD and multiplier loops, and power
// runs up to four multiplies (two squares and two products) per exponent bit.
// One item is in flight at a time; busy stays high until its result strobe.
// Synchronous reset returns the sequencer to idle and clears the strobe.
`default_nettype none
module rational_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_type,
   input  wire logic        req_a_negative,
   input  wire logic [31:0] req_a_numerator,
   input  wire logic [31:0] req_a_denominator,
   input  wire logic        req_b_negative,
   input  wire logic [31:0] req_b_numerator,
   input  wire logic [31:0] req_b_denominator,
   output logic             rsp_valid,
   output logic             rsp_r_negative,
   output logic [31:0]      rsp_r_numerator,
   output logic [31:0]      rsp_r_denominator,
   output logic             rsp_less_equal,
   output logic             rsp_equal_flag,
   output logic [1:0]       rsp_status
);
   import rau_pkg::*;

   localparam logic [63:0] Lim = (WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << WIDTH) - 64'd1);

   typedef enum logic [5:0] {
      S_IDLE, S_CHECK, S_RED, S_RED_G, S_RED_N, S_RED_D, S_CMP, S_CMP_1, S_CMP_2,
      S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_A8, S_A9, S_A10, S_A11,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_FIN
   } state_type;

   state_type     state_ff;
   logic [2:0]    op_ff;
   logic [31:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic          aneg_ff, bneg_ff, side_ff;
   logic [31:0]   g_ff, g2_ff, q1_ff;
   logic [63:0]   x_ff, y_ff;
   logic [64:0]   t_ff;
   logic          sg_ff;
   logic [64:0]   rn_ff;
   logic [63:0]   rd_ff;
   logic          rneg_ff, le_ff, eq_ff;
   logic [1:0]    st_ff;
   logic [63:0]   bsn_ff, bsd_ff, pn_ff, pd_ff;
   logic [31:0]   e_ff;
   logic          bover_ff;

   logic          gcd_start_ff, div_start_ff, mul_start_ff;
   logic [31:0]   gcd_x_ff, gcd_y_ff, div_den_ff;
   logic [64:0]   div_num_ff;
   logic [63:0]   mul_a_ff, mul_b_ff;
   logic          gcd_done, div_done, mul_done;
   logic [31:0]   gcd_res, div_rem;
   logic [64:0]   div_quot;
   logic [127:0]  mul_prod;

   logic          rsp_valid_ff, rsp_neg_ff, rsp_le_ff, rsp_eq_ff;
   logic [31:0]   rsp_num_ff, rsp_den_ff;
   logic [1:0]    rsp_st_ff;

   logic          beff;
   logic [64:0]   add_t;
   logic          add_sg;
   logic          mul_over;
   logic [31:0]   red_num, red_den;
   logic [1:0]    fin_st;
   logic          fin_zero;

   rau_gcd u_gcd (
      .clock(clock), .reset(reset), .start(gcd_start_ff), .op_x(gcd_x_ff), .op_y(gcd_y_ff),
      .done(gcd_done), .result(gcd_res)
   );

   rau_div u_div (
      .clock(clock), .reset(reset), .start(div_start_ff), .dividend(div_num_ff),
      .divisor(div_den_ff), .done(div_done), .quotient(div_quot), .remainder(div_rem)
   );

   rau_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff), .op_a(mul_a_ff), .op_b(mul_b_ff),
      .done(mul_done), .product(mul_prod)
   );

   always_comb begin
      beff = (op_ff == OP_SUB) ? ~bneg_ff : bneg_ff;
      if (aneg_ff == beff) begin
         add_t = {1'b0, x_ff} + {1'b0, y_ff};
         add_sg = aneg_ff;
      end else if (x_ff >= y_ff) begin
         add_t = {1'b0, x_ff - y_ff};
         add_sg = aneg_ff;
      end else begin
         add_t = {1'b0, y_ff - x_ff};
         add_sg = beff;
      end
      mul_over = (|mul_prod[127:64]) || (mul_prod[63:0] > Lim);
      red_num = side_ff ? bn_ff : an_ff;
      red_den = side_ff ? bd_ff : ad_ff;
      fin_st = st_ff;
      if (st_ff == ST_OK && (rn_ff > {1'b0, Lim} || rd_ff > Lim)) begin
         fin_st = ST_OVERFLOW;
      end
      fin_zero = (fin_st != ST_OK) || (rn_ff == '0);
   end

   always_ff @(posedge clock) begin
      gcd_start_ff <= 1'b0;
      div_start_ff <= 1'b0;
      mul_start_ff <= 1'b0;
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff <= req_type;
                  an_ff <= req_a_numerator;
                  ad_ff <= req_a_denominator;
                  aneg_ff <= req_a_negative;
                  bn_ff <= req_b_numerator;
                  bd_ff <= req_b_denominator;
                  bneg_ff <= req_b_negative;
                  st_ff <= ST_OK;
                  rn_ff <= '0;
                  rd_ff <= 64'd1;
                  rneg_ff <= 1'b0;
                  le_ff <= 1'b0;
                  eq_ff <= 1'b0;
                  side_ff <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (ad_ff == '0 || bd_ff == '0) begin
                  st_ff <= ST_DIV_ZERO;
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_RED;
               end
            end
            S_RED: begin
               if (red_num == '0) begin
                  if (side_ff) begin
                     bd_ff <= 32'd1;
                     bneg_ff <= 1'b0;
                     state_ff <= S_CMP;
                  end else begin
                     ad_ff <= 32'd1;
                     aneg_ff <= 1'b0;
                     side_ff <= 1'b1;
                  end
               end else begin
                  gcd_x_ff <= red_num;
                  gcd_y_ff <= red_den;
                  gcd_start_ff <= 1'b1;
                  state_ff <= S_RED_G;
               end
            end
            S_RED_G: begin
               if (gcd_done) begin
                  g_ff <= gcd_res;
                  div_num_ff <= {33'd0, red_num};
                  div_den_ff <= gcd_res;
                  div_start_ff <= 1'b1;
                  state_ff <= S_RED_N;
               end
            end
            S_RED_N: begin
               if (div_done) begin
                  if (side_ff) bn_ff <= div_quot[31:0];
                  else an_ff <= div_quot[31:0];
                  div_num_ff <= {33'd0, red_den};
                  div_den_ff <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_RED_D;
               end
            end
            S_RED_D: begin
               if (div_done) begin
                  if (side_ff) begin
                     bd_ff <= div_quot[31:0];
                     state_ff <= S_CMP;
                  end else begin
                     ad_ff <= div_quot[31:0];
                     side_ff <= 1'b1;
                     state_ff <= S_RED;
                  end
               end
            end
            S_CMP: begin
               eq_ff <= (aneg_ff == bneg_ff) && (an_ff == bn_ff) && (ad_ff == bd_ff);
               mul_a_ff <= {32'd0, an_ff};
               mul_b_ff <= {32'd0, bd_ff};
               mul_start_ff <= 1'b1;
               state_ff <= S_CMP_1;
            end
            S_CMP_1: begin
               if (mul_done) begin
                  x_ff <= mul_prod[63:0];
                  mul_a_ff <= {32'd0, bn_ff};
                  mul_b_ff <= {32'd0, ad_ff};
                  mul_start_ff <= 1'b1;
                  state_ff <= S_CMP_2;
               end
            end
            S_CMP_2: begin
               if (mul_done) begin
                  if (aneg_ff != bneg_ff) le_ff <= aneg_ff;
                  else if (aneg_ff) le_ff <= mul_prod[63:0] <= x_ff;
                  else le_ff <= x_ff <= mul_prod[63:0];
                  case (op_ff) inside
                     OP_ADD, OP_SUB: state_ff <= S_A0;
                     OP_MUL, OP_DIV: state_ff <= S_M0;
                     OP_POW: state_ff <= S_P0;
                     default: state_ff <= S_FIN;
                  endcase
               end
            end
            S_A0: begin
               gcd_x_ff <= ad_ff;
               gcd_y_ff <= bd_ff;
               gcd_start_ff <= 1'b1;
               state_ff <= S_A1;
            end
            S_A1: begin
               if (gcd_done) begin
                  g_ff <= gcd_res;
                  div_num_ff <= {33'd0, bd_ff};
                  div_den_ff <= gcd_res;
                  div_start_ff <= 1'b1;
                  state_ff <= S_A2;
               end
            end
            S_A2: begin
               if (div_done) begin
                  g2_ff <= div_quot[31:0];
                  div_num_ff <= {33'd0, ad_ff};
                  div_den_ff <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_A3;
               end
            end
            S_A3: begin
               if (div_done) begin
                  q1_ff <= div_quot[31:0];
                  mul_a_ff <= {32'd0, an_ff};
                  mul_b_ff <= {32'd0, g2_ff};
                  mul_start_ff <= 1'b1;
                  state_ff <= S_A4;
               end
            end
            S_A4: begin
               if (mul_done) begin
                  x_ff <= mul_prod[63:0];
                  mul_a_ff <= {32'd0, bn_ff};
                  mul_b_ff <= {32'd0, q1_ff};
                  mul_start_ff <= 1'b1;
                  state_ff <= S_A5;
               end
            end
            S_A5: begin
               if (mul_done) begin
                  y_ff <= mul_prod[63:0];
                  state_ff <= S_A6;
               end
            end
            S_A6: begin
               t_ff <= add_t;
               sg_ff <= add_sg;
               if (add_t == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  div_num_ff <= add_t;
                  div_den_ff <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_A7;
               end
            end
            S_A7: begin
               if (div_done) begin
                  gcd_x_ff <= div_rem;
                  gcd_y_ff <= g_ff;
                  gcd_start_ff <= 1'b1;
                  state_ff <= S_A8;
               end
            end
            S_A8: begin
               if (gcd_done) begin
                  g2_ff <= gcd_res;
                  div_num_ff <= t_ff;
                  div_den_ff <= gcd_res;
                  div_start_ff <= 1'b1;
                  state_ff <= S_A9;
               end
            end
            S_A9: begin
               if (div_done) begin
                  rn_ff <= div_quot;
                  div_num_ff <= {33'd0, bd_ff};
                  div_den_ff <= g2_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_A10;
               end
            end
            S_A10: begin
               if (div_done) begin
                  mul_a_ff <= {32'd0, q1_ff};
                  mul_b_ff <= {32'd0, div_quot[31:0]};
                  mul_start_ff <= 1'b1;
                  state_ff <= S_A11;
               end
            end
            S_A11: begin
               if (mul_done) begin
                  rd_ff <= mul_prod[63:0];
                  rneg_ff <= sg_ff;
                  state_ff <= S_FIN;
               end
            end
            S_M0: begin
               if (op_ff == OP_DIV && bn_ff == '0) begin
                  st_ff <= ST_DIV_ZERO;
                  state_ff <= S_FIN;
               end else begin
                  if (op_ff == OP_DIV) begin
                     bn_ff <= bd_ff;
                     bd_ff <= bn_ff;
                  end
                  state_ff <= S_M1;
               end
            end
            S_M1: begin
               if (an_ff == '0 || bn_ff == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  gcd_x_ff <= an_ff;
                  gcd_y_ff <= bd_ff;
                  gcd_start_ff <= 1'b1;
                  state_ff <= S_M2;
               end
            end
            S_M2: begin
               if (gcd_done) begin
                  g_ff <= gcd_res;
                  gcd_x_ff <= ad_ff;
                  gcd_y_ff <= bn_ff;
                  gcd_start_ff <= 1'b1;
                  state_ff <= S_M3;
               end
            end
            S_M3: begin
               if (gcd_done) begin
                  g2_ff <= gcd_res;
                  div_num_ff <= {33'd0, an_ff};
                  div_den_ff <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_M4;
               end
            end
            S_M4: begin
               if (div_done) begin
                  q1_ff <= div_quot[31:0];
                  div_num_ff <= {33'd0, bn_ff};
                  div_den_ff <= g2_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_M5;
               end
            end
            S_M5: begin
               if (div_done) begin
                  mul_a_ff <= {32'd0, q1_ff};
                  mul_b_ff <= {32'd0, div_quot[31:0]};
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M6;
               end
            end
            S_M6: begin
               if (mul_done) begin
                  rn_ff <= {1'b0, mul_prod[63:0]};
                  div_num_ff <= {33'd0, ad_ff};
                  div_den_ff <= g2_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_M7;
               end
            end
            S_M7: begin
               if (div_done) begin
                  q1_ff <= div_quot[31:0];
                  div_num_ff <= {33'd0, bd_ff};
                  div_den_ff <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff <= S_M8;
               end
            end
            S_M8: begin
               if (div_done) begin
                  mul_a_ff <= {32'd0, q1_ff};
                  mul_b_ff <= {32'd0, div_quot[31:0]};
                  mul_start_ff <= 1'b1;
                  state_ff <= S_M9;
               end
            end
            S_M9: begin
               if (mul_done) begin
                  rd_ff <= mul_prod[63:0];
                  rneg_ff <= aneg_ff ^ bneg_ff;
                  state_ff <= S_FIN;
               end
            end
            S_P0: begin
               if (bd_ff != 32'd1) begin
                  st_ff <= ST_NON_INT;
                  state_ff <= S_FIN;
               end else if (bn_ff == '0) begin
                  rn_ff <= 65'd1;
                  state_ff <= S_FIN;
               end else if (an_ff == '0) begin
                  if (bneg_ff) st_ff <= ST_DIV_ZERO;
                  state_ff <= S_FIN;
               end else begin
                  bsn_ff <= {32'd0, bneg_ff ? ad_ff : an_ff};
                  bsd_ff <= {32'd0, bneg_ff ? an_ff : ad_ff};
                  pn_ff <= 64'd1;
                  pd_ff <= 64'd1;
                  e_ff <= bn_ff;
                  bover_ff <= 1'b0;
                  state_ff <= S_P1;
               end
            end
            S_P1: begin
               if (e_ff == '0) begin
                  rn_ff <= {1'b0, pn_ff};
                  rd_ff <= pd_ff;
                  rneg_ff <= aneg_ff & bn_ff[0];
                  state_ff <= S_FIN;
               end else if (e_ff[0]) begin
                  if (bover_ff) begin
                     st_ff <= ST_OVERFLOW;
                     state_ff <= S_FIN;
                  end else begin
                     mul_a_ff <= pn_ff;
                     mul_b_ff <= bsn_ff;
                     mul_start_ff <= 1'b1;
                     state_ff <= S_P2;
                  end
               end else begin
                  state_ff <= S_P4;
               end
            end
            S_P2: begin
               if (mul_done) begin
                  if (mul_over) begin
                     st_ff <= ST_OVERFLOW;
                     state_ff <= S_FIN;
                  end else begin
                     x_ff <= mul_prod[63:0];
                     mul_a_ff <= pd_ff;
                     mul_b_ff <= bsd_ff;
                     mul_start_ff <= 1'b1;
                     state_ff <= S_P3;
                  end
               end
            end
            S_P3: begin
               if (mul_done) begin
                  if (mul_over) begin
                     st_ff <= ST_OVERFLOW;
                     state_ff <= S_FIN;
                  end else begin
                     pn_ff <= x_ff;
                     pd_ff <= mul_prod[63:0];
                     state_ff <= S_P4;
                  end
               end
            end
            S_P4: begin
               e_ff <= e_ff >> 1;
               if ((e_ff >> 1) != '0 && !bover_ff) begin
                  mul_a_ff <= bsn_ff;
                  mul_b_ff <= bsn_ff;
                  mul_start_ff <= 1'b1;
                  state_ff <= S_P5;
               end else begin
                  state_ff <= S_P1;
               end
            end
            S_P5: begin
               if (mul_done) begin
                  if (mul_over) begin
                     bover_ff <= 1'b1;
                     state_ff <= S_P1;
                  end else begin
                     x_ff <= mul_prod[63:0];
                     mul_a_ff <= bsd_ff;
                     mul_b_ff <= bsd_ff;
                     mul_start_ff <= 1'b1;
                     state_ff <= S_P6;
                  end
               end
            end
            S_P6: begin
               if (mul_done) begin
                  if (mul_over) begin
                     bover_ff <= 1'b1;
                  end else begin
                     bsn_ff <= x_ff;
                     bsd_ff <= mul_prod[63:0];
                  end
                  state_ff <= S_P1;
               end
            end
            S_FIN: begin
               rsp_valid_ff <= 1'b1;
               rsp_neg_ff <= fin_zero ? 1'b0 : rneg_ff;
               rsp_num_ff <= fin_zero ? 32'd0 : rn_ff[31:0];
               rsp_den_ff <= fin_zero ? 32'd1 : rd_ff[31:0];
               rsp_le_ff <= le_ff;
               rsp_eq_ff <= eq_ff;
               rsp_st_ff <= fin_st;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_r_negative = rsp_neg_ff;
   assign rsp_r_numerator = rsp_num_ff;
   assign rsp_r_denominator = rsp_den_ff;
   assign rsp_less_equal = rsp_le_ff;
   assign rsp_equal_flag = rsp_eq_ff;
   assign rsp_status = rsp_st_ff;

`ifndef SYNTHESIS
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_r_denominator != '0)
      else $error("Result item has a zero denominator.");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_r_numerator == '0 && !rsp_r_negative)
      else $error("Error result item is not a positive zero.");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted item did not raise busy.");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result strobe while the sequencer is still busy.");
`endif
endmodule
`default_nettype wire

/* sim/rational_arithmetic_unit_tb.sv */
// Self-checking testbench for the rational arithmetic unit: random and directed items.
`default_nettype none
module rational_arithmetic_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam logic [63:0] LIMIT_MASK = 64'hFFFF_FFFF;
   localparam int IDLE_LIMIT = 40000;
   localparam int RANDOM_ITEMS = 1530;

   typedef struct packed {
      logic        negative;
      logic [31:0] numerator;
      logic [31:0] denominator;
      logic        less_equal;
      logic        equal_flag;
      logic [1:0]  status;
   } rational_result_type;

   class rational_scoreboard_type;
      rational_result_type expected_results[$];
      int errors = 0;

      function automatic logic [63:0] binary_gcd(logic [63:0] x, logic [63:0] y);
         int k;
         logic [63:0] t;
         k = 0;
         if (x == 0) return y;
         if (y == 0) return x;
         while (((x | y) & 1) == 0) begin
            x >>= 1;
            y >>= 1;
            k++;
         end
         while (x[0] == 0) x >>= 1;
         while (y != 0) begin
            while (y[0] == 0) y >>= 1;
            if (x > y) begin
               t = x;
               x = y;
               y = t;
            end
            y -= x;
         end
         return x << k;
      endfunction

      function automatic void reduce(inout logic [63:0] n, inout logic [63:0] d,
                                     inout logic neg);
         logic [63:0] g;
         if (n == 0) begin
            d = 1;
            neg = 0;
            return;
         end
         g = binary_gcd(n, d);
         n /= g;
         d /= g;
      endfunction

      function automatic logic [1:0] sum(logic [63:0] an, logic [63:0] ad, logic aneg,
                                         logic [63:0] bn, logic [63:0] bd, logic bneg,
                                         output logic [64:0] rn, output logic [63:0] rd,
                                         output logic rneg);
         logic [63:0] g, g2, x, y;
         logic [64:0] t;
         logic sg;
         g = binary_gcd(ad, bd);
         x = an * (bd / g);
         y = bn * (ad / g);
         rn = 0;
         rd = 1;
         rneg = 0;
         if (aneg == bneg) begin
            t = {1'b0, x} + {1'b0, y};
            sg = aneg;
         end else if (x >= y) begin
            t = {1'b0, x - y};
            sg = aneg;
         end else begin
            t = {1'b0, y - x};
            sg = bneg;
         end
         if (t == 0) return ST_OK;
         g2 = binary_gcd(64'(t % g), g);
         rn = t / g2;
         rd = (ad / g) * (bd / g2);
         rneg = sg;
         return ST_OK;
      endfunction

      function automatic bit product_over(logic [63:0] x, logic [63:0] y);
         return x != 0 && x * y > LIMIT_MASK;
      endfunction

      function automatic logic [1:0] power(logic [63:0] an, logic [63:0] ad, logic aneg,
                                           logic [63:0] bn, logic [63:0] bd, logic bneg,
                                           output logic [64:0] rn, output logic [63:0] rd,
                                           output logic rneg);
         logic [63:0] base_n, base_d, e, pn, pd;
         bit squared_over;
         rn = 0;
         rd = 1;
         rneg = 0;
         squared_over = 0;
         pn = 1;
         pd = 1;
         if (bd != 1) return ST_NON_INT;
         if (bn == 0) begin
            rn = 1;
            return ST_OK;
         end
         if (an == 0) return bneg ? ST_DIV_ZERO : ST_OK;
         if (bneg) begin
            base_n = ad;
            base_d = an;
         end else begin
            base_n = an;
            base_d = ad;
         end
         e = bn;
         while (e != 0) begin
            if (e[0]) begin
               if (squared_over || product_over(pn, base_n) || product_over(pd, base_d))
                  return ST_OVERFLOW;
               pn *= base_n;
               pd *= base_d;
            end
            e >>= 1;
            if (e != 0 && !squared_over) begin
               if (product_over(base_n, base_n) || product_over(base_d, base_d))
                  squared_over = 1;
               else begin
                  base_n *= base_n;
                  base_d *= base_d;
               end
            end
         end
         rn = pn;
         rd = pd;
         rneg = aneg && bn[0];
         return ST_OK;
      endfunction

      function automatic rational_result_type compute(logic [2:0] op, logic aneg,
                                                      logic [63:0] an, logic [63:0] ad,
                                                      logic bneg, logic [63:0] bn,
                                                      logic [63:0] bd);
         rational_result_type r;
         logic [64:0] rn;
         logic [63:0] rd, g1, g2, t;
         logic rneg;
         logic [1:0] st;
         r = '0;
         rn = 0;
         rd = 1;
         rneg = 0;
         st = ST_OK;
         if (ad == 0 || bd == 0) begin
            st = ST_DIV_ZERO;
         end else begin
            reduce(an, ad, aneg);
            reduce(bn, bd, bneg);
            r.equal_flag = (aneg == bneg) && an == bn && ad == bd;
            if (aneg != bneg) r.less_equal = aneg;
            else if (aneg) r.less_equal = (bn * ad) <= (an * bd);
            else r.less_equal = (an * bd) <= (bn * ad);
            case (op) inside
               OP_ADD, OP_SUB: begin
                  st = sum(an, ad, aneg, bn, bd, (op == OP_SUB) ? !bneg : bneg,
                           rn, rd, rneg);
               end
               OP_MUL, OP_DIV: begin
                  if (op == OP_DIV) begin
                     if (bn == 0) st = ST_DIV_ZERO;
                     t = bn;
                     bn = bd;
                     bd = t;
                  end
                  if (st == ST_OK && an != 0 && bn != 0) begin
                     g1 = binary_gcd(an, bd);
                     g2 = binary_gcd(ad, bn);
                     rn = (an / g1) * (bn / g2);
                     rd = (ad / g2) * (bd / g1);
                     rneg = aneg != bneg;
                  end
               end
               OP_POW: begin
                  st = power(an, ad, aneg, bn, bd, bneg, rn, rd, rneg);
               end
               default: ;
            endcase
            if (st == ST_OK && (rn > LIMIT_MASK || rd > LIMIT_MASK)) st = ST_OVERFLOW;
         end
         if (st != ST_OK || rn == 0) begin
            rn = 0;
            rd = 1;
            rneg = 0;
         end
         r.negative = rneg;
         r.numerator = rn[31:0];
         r.denominator = rd[31:0];
         r.status = st;
         return r;
      endfunction

      function void note_request(logic [2:0] op, logic aneg, logic [31:0] an,
                                 logic [31:0] ad, logic bneg, logic [31:0] bn,
                                 logic [31:0] bd);
         expected_results.insert(expected_results.size(),
                                 compute(op, aneg, 64'(an), 64'(ad), bneg, 64'(bn),
                                         64'(bd)));
      endfunction

      function void check_result(rational_result_type actual);
         rational_result_type e;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %p", $realtime, actual);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         if (actual.negative !== e.negative) begin
            $display("%0t: r_negative expected %0d actual %0d", $realtime,
                     e.negative, actual.negative);
            errors++;
         end
         if (actual.numerator !== e.numerator) begin
            $display("%0t: r_numerator expected %0d actual %0d", $realtime,
                     e.numerator, actual.numerator);
            errors++;
         end
         if (actual.denominator !== e.denominator) begin
            $display("%0t: r_denominator expected %0d actual %0d", $realtime,
                     e.denominator, actual.denominator);
            errors++;
         end
         if (actual.less_equal !== e.less_equal) begin
            $display("%0t: less_equal expected %0d actual %0d", $realtime,
                     e.less_equal, actual.less_equal);
            errors++;
         end
         if (actual.equal_flag !== e.equal_flag) begin
            $display("%0t: equal_flag expected %0d actual %0d", $realtime,
                     e.equal_flag, actual.equal_flag);
            errors++;
         end
         if (actual.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     e.status, actual.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_type = '0;
   logic req_a_negative = 0;
   logic [31:0] req_a_numerator = '0;
   logic [31:0] req_a_denominator = '0;
   logic req_b_negative = 0;
   logic [31:0] req_b_numerator = '0;
   logic [31:0] req_b_denominator = '0;
   logic rsp_valid, rsp_r_negative, rsp_less_equal, rsp_equal_flag;
   logic [31:0] rsp_r_numerator, rsp_r_denominator;
   logic [1:0] rsp_status;

   rational_scoreboard_type results_sb = new();
   int idle_cycles = 0;

   rational_arithmetic_unit DUT (
      .clock, .reset, .start, .busy,
      .req_type, .req_a_negative, .req_a_numerator, .req_a_denominator,
      .req_b_negative, .req_b_numerator, .req_b_denominator,
      .rsp_valid, .rsp_r_negative, .rsp_r_numerator, .rsp_r_denominator,
      .rsp_less_equal, .rsp_equal_flag, .rsp_status
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_sb.check_result('{rsp_r_negative, rsp_r_numerator, rsp_r_denominator,
                                   rsp_less_equal, rsp_equal_flag, rsp_status});
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Drives one item and holds it until the unit takes it.
   task automatic send_item(logic [2:0] op, logic aneg, logic [31:0] an, logic [31:0] ad,
                            logic bneg, logic [31:0] bn, logic [31:0] bd);
      req_type <= op;
      req_a_negative <= aneg;
      req_a_numerator <= an;
      req_a_denominator <= ad;
      req_b_negative <= bneg;
      req_b_numerator <= bn;
      req_b_denominator <= bd;
      start <= 1;
      do @(posedge clock); while (busy);
      results_sb.note_request(op, aneg, an, ad, bneg, bn, bd);
   endtask

   task automatic pause_sender(int cycles);
      start <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_results();
      start <= 0;
      do @(posedge clock); while (results_sb.expected_results.size() != 0);
   endtask

   function automatic logic [31:0] random_magnitude();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 12);
         1: return $urandom_range(0, 1000);
         2: return $urandom_range(0, 65535);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_denominator();
      logic [31:0] d;
      if ($urandom_range(0, 31) == 0) return 0;
      d = random_magnitude();
      return (d == 0) ? 1 : d;
   endfunction

   task automatic send_random_item();
      logic [2:0] op;
      logic [31:0] an, ad, bn, bd, k;
      op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      an = random_magnitude();
      ad = random_denominator();
      bn = random_magnitude();
      bd = random_denominator();
      if ($urandom_range(0, 3) == 0 && ad < 1000 && an < 1000) begin
         k = $urandom_range(2, 30);
         an *= k;
         ad *= k;
      end
      if (op == OP_POW) begin
         an = $urandom_range(0, 3) == 0 ? random_magnitude() : $urandom_range(0, 9);
         ad = $urandom_range(0, 3) == 0 ? random_denominator() : $urandom_range(1, 5);
         case ($urandom_range(0, 9))
            0: bd = random_denominator();
            1: begin
               k = $urandom_range(2, 9);
               bd = k;
               bn = k * $urandom_range(0, 12);
            end
            2: bd = 1;
            default: begin
               bd = 1;
               bn = $urandom_range(0, 40);
            end
         endcase
      end
      send_item(op, 1'($urandom), an, ad, 1'($urandom), bn, bd);
   endtask

   initial begin
      int burst;
      int sent;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(OP_ADD, 0, 1, 2, 0, 1, 3);
      send_item(OP_SUB, 1, 3, 4, 1, 6, 8);
      send_item(OP_MUL, 1, 4, 9, 1, 3, 8);
      send_item(OP_DIV, 0, 5, 7, 1, 0, 3);
      send_item(OP_ADD, 0, 5, 0, 0, 1, 1);
      send_item(OP_MUL, 0, 5, 3, 0, 1, 0);
      send_item(OP_POW, 0, 0, 1, 1, 1, 1);
      send_item(OP_POW, 0, 0, 1, 0, 0, 1);
      send_item(OP_POW, 1, 7, 3, 0, 1, 2);
      send_item(OP_POW, 0, 2, 1, 0, 40, 1);
      send_item(OP_POW, 1, 2, 3, 1, 3, 1);
      send_item(OP_POW, 1, 1, 1, 0, 32'hFFFF_FFFF, 1);
      send_item(OP_POW, 0, 6, 4, 0, 6, 2);
      send_item(OP_ADD, 1, 0, 5, 0, 0, 7);
      send_item(3'd5, 1, 2, 3, 1, 1, 3);
      send_item(3'd6, 0, 1, 1, 0, 1, 1);
      send_item(3'd7, 1, 1, 2, 0, 1, 2);
      send_item(OP_ADD, 0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 1);
      send_item(OP_SUB, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_MUL, 0, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1);
      send_item(OP_DIV, 1, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1);
      send_item(OP_ADD, 1, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFE);
      wait_for_results();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            send_random_item();
            sent++;
         end
         if (sent > RANDOM_ITEMS / 2 && sent <= RANDOM_ITEMS / 2 + burst) wait_for_results();
         else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 10));
      end

      wait_for_results();
      repeat (50) @(posedge clock);
      if (results_sb.errors == 0 && results_sb.expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire
